// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, abandoned while reset is high
`define CHK_ASSERT(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked property that is also checked through reset
`define CHK_ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/pidvdt_pkg.sv =====
// types, widths and register codes of the variable interval pid controller
package pidvdt_pkg;

  localparam int GAIN_W    = 16;
  localparam int TIME_W    = 32;
  localparam int VAL_W     = 16;
  localparam int ERR_W     = VAL_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int INTEG_W   = 48;
  localparam int ACC_W     = 64;
  localparam int DRIVE_W   = 32;
  localparam int MPLIER_W  = TIME_W + 1;
  localparam int STEP_W    = $clog2(MPLIER_W + 1);
  localparam int QUO_W     = DIFF_W - 1;
  localparam int CFG_IDX_W = 2;

  localparam int GAIN_FRAC_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic        [TIME_W-1:0] timestamp_ms;
    logic signed [VAL_W-1:0]  measurement;
    logic signed [VAL_W-1:0]  target;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      zero_interval;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic                    load;
    logic [STEP_W-1:0]       steps;
    logic [MPLIER_W-1:0]     mplier;
    logic signed [ACC_W-1:0] mcand;
    logic signed [ACC_W-1:0] init;
  } mul_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc;
  } mul_sts_t;

endpackage

// ===== hdl/pidvdt_smul.sv =====
// bit-serial shift-add multiply-accumulate unit, top multiplier bit weighted negative
module pidvdt_smul (
  input  logic                 clk,
  input  logic                 rst,
  input  pidvdt_pkg::mul_cmd_t cmd,
  output pidvdt_pkg::mul_sts_t sts
);
  import pidvdt_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] mcand;
  logic [MPLIER_W-1:0]     mplier;
  logic [STEP_W-1:0]       count;
  logic                    busy;
  logic                    done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        if (cmd.load) begin
          acc <= cmd.init;
        end
        mcand  <= cmd.mcand;
        mplier <= cmd.mplier;
        count  <= cmd.steps;
        busy   <= 1'b1;
      end else if (busy) begin
        // last step carries the sign weight of the multiplier
        if (mplier[0]) begin
          if (count == STEP_W'(1)) begin
            acc <= acc - mcand;
          end else begin
            acc <= acc + mcand;
          end
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        count  <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done;
  assign sts.acc  = acc;

endmodule

// ===== hdl/pidvdt_sdiv.sv =====
// restoring bit-serial divider, one quotient bit a cycle
module pidvdt_sdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidvdt_pkg::QUO_W-1:0]  dividend,
  input  logic [pidvdt_pkg::TIME_W-1:0] divisor,
  output logic [pidvdt_pkg::QUO_W-1:0]  quotient
);
  import pidvdt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [QUO_W-1:0]  dq;
  logic [CNT_W-1:0]  count;
  logic              busy;

  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   trial;
  logic              fits;

  assign shifted = {rem, dq[QUO_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      rem   <= '0;
      dvs   <= divisor;
      dq    <= dividend;
      count <= CNT_W'(QUO_W);
      busy  <= 1'b1;
    end else if (busy) begin
      // dividend bits leave at the top while quotient bits enter at the bottom
      rem   <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
      dq    <= {dq[QUO_W-2:0], fits};
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = dq;

endmodule

// ===== hdl/pid_controller_variable_dt.sv =====
// top level of the parallel-form pid controller with variable sample interval
// a sample runs states int, prop, intg, deriv and out to its registered result;
// a new sample waits until idle, held by output stalls and the bit-serial multiplier
//   (33 steps for error times interval, then 16 steps for each gain product)
// reset clears gains, previous time, previous error, integral and the handshakes
module pid_controller_variable_dt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  pidvdt_pkg::sample_t              sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output pidvdt_pkg::result_t              result,
  input  logic                             write_enable,
  input  logic [pidvdt_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [pidvdt_pkg::GAIN_W-1:0]    write_data
);
  import pidvdt_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a sample
  localparam logic [2:0] ST_INT   = 3'd1;  // integral plus error times interval
  localparam logic [2:0] ST_PROP  = 3'd2;  // proportional product
  localparam logic [2:0] ST_INTG  = 3'd3;  // integral product
  localparam logic [2:0] ST_DERIV = 3'd4;  // derivative product
  localparam logic [2:0] ST_OUT   = 3'd5;  // hand result to the output register

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  logic [2:0] state;

  // gains, signed with GAIN_FRAC_BITS fraction bits
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;

  // controller state carried from sample to sample
  logic [TIME_W-1:0]         previous_time;
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   previous_error;

  // per-sample working registers
  logic signed [ERR_W-1:0]   err;
  logic                      diff_neg;
  logic                      zero;
  logic                      sat;

  logic                      accept;
  logic [TIME_W-1:0]         elapsed_now;
  logic signed [ERR_W-1:0]   err_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic [DIFF_W-1:0]         diff_mag;
  logic [QUO_W-1:0]          quo;
  logic signed [DIFF_W-1:0]  deriv;

  mul_cmd_t                  mul_cmd;
  mul_sts_t                  mul_sts;

  logic                      sum_ovf;
  logic signed [INTEG_W-1:0] sum_sat;
  logic signed [ACC_W-1:0]   acc_shifted;
  logic                      drive_ovf;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // front end: interval, error and change of error, all in the accept cycle
  assign elapsed_now = sample.timestamp_ms - previous_time;
  assign err_now     = ERR_W'(sample.target) - ERR_W'(sample.measurement);
  assign diff_now    = DIFF_W'(err_now) - DIFF_W'(previous_error);
  assign diff_mag    = diff_now[DIFF_W-1] ? DIFF_W'(-diff_now) : DIFF_W'(diff_now);

  // magnitude division runs alongside the first multiply and is long done by its end
  pidvdt_sdiv u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (diff_mag[QUO_W-1:0]),
    .divisor  (elapsed_now),
    .quotient (quo)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  always_comb begin
    if (zero) begin
      deriv = '0;
    end else if (diff_neg) begin
      deriv = -$signed({1'b0, quo});
    end else begin
      deriv = $signed({1'b0, quo});
    end
  end

  pidvdt_smul u_smul (
    .clk (clk),
    .rst (rst),
    .cmd (mul_cmd),
    .sts (mul_sts)
  );

  // integral clamp on the accumulated sum
  assign sum_ovf = mul_sts.acc[ACC_W-1:INTEG_W-1] != {(ACC_W-INTEG_W+1){mul_sts.acc[INTEG_W-1]}};
  assign sum_sat = sum_ovf ? (mul_sts.acc[ACC_W-1] ? INTEG_MIN : INTEG_MAX)
                           : mul_sts.acc[INTEG_W-1:0];

  // floor shift by the gain fraction bits, then clamp to the drive range
  assign acc_shifted = mul_sts.acc >>> GAIN_FRAC_BITS;
  assign drive_ovf   = acc_shifted[ACC_W-1:DRIVE_W-1] !=
                       {(ACC_W-DRIVE_W+1){acc_shifted[DRIVE_W-1]}};
  assign drive_sat   = drive_ovf ? (acc_shifted[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX)
                                 : acc_shifted[DRIVE_W-1:0];

  // multiplier commands, one per product, issued on entry to each state
  always_comb begin
    mul_cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          // integral + error * interval, interval taken as a positive 33-bit value
          mul_cmd.start  = 1'b1;
          mul_cmd.load   = 1'b1;
          mul_cmd.steps  = STEP_W'(MPLIER_W);
          mul_cmd.mplier = {1'b0, elapsed_now};
          mul_cmd.mcand  = ACC_W'(err_now);
          mul_cmd.init   = ACC_W'(error_integral);
        end
      end
      ST_INT: begin
        if (mul_sts.done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.load   = 1'b1;
          mul_cmd.steps  = STEP_W'(GAIN_W);
          mul_cmd.mplier = MPLIER_W'(gain_p);
          mul_cmd.mcand  = ACC_W'(err);
          mul_cmd.init   = '0;
        end
      end
      ST_PROP: begin
        if (mul_sts.done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.steps  = STEP_W'(GAIN_W);
          mul_cmd.mplier = MPLIER_W'(gain_i);
          mul_cmd.mcand  = ACC_W'(error_integral);
        end
      end
      ST_INTG: begin
        if (mul_sts.done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.steps  = STEP_W'(GAIN_W);
          mul_cmd.mplier = MPLIER_W'(gain_d);
          mul_cmd.mcand  = ACC_W'(deriv);
        end
      end
      default: begin
        mul_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      previous_time  <= '0;
      error_integral <= '0;
      previous_error <= '0;
      result_valid   <= 1'b0;
    end else begin
      // gain writes must only arrive while idle, unchecked; spare index is dropped
      if (write_enable) begin
        unique case (write_index)
          REG_GAIN_P: gain_p <= write_data;
          REG_GAIN_I: gain_i <= write_data;
          REG_GAIN_D: gain_d <= write_data;
          default: begin
          end
        endcase
      end

      // output transaction taken, unless a new result replaces it this cycle
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            err            <= err_now;
            diff_neg       <= diff_now[DIFF_W-1];
            zero           <= (elapsed_now == '0);
            sat            <= 1'b0;
            previous_time  <= sample.timestamp_ms;
            previous_error <= err_now;
            state          <= ST_INT;
          end
        end
        ST_INT: begin
          if (mul_sts.done) begin
            error_integral <= sum_sat;
            sat            <= sum_ovf;
            state          <= ST_PROP;
          end
        end
        ST_PROP: begin
          if (mul_sts.done) begin
            state <= ST_INTG;
          end
        end
        ST_INTG: begin
          if (mul_sts.done) begin
            state <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          if (mul_sts.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // wait for room in the output register
          if (!result_valid || !result_stall) begin
            result.drive         <= drive_sat;
            result.zero_interval <= zero;
            result.saturated     <= sat | drive_ovf;
            result_valid         <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pidvdt_chk.sv =====
// port-level checker for the pid controller, bound to the top level
`include "assert_macros.svh"

module pidvdt_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_valid,
  input logic                             sample_stall,
  input pidvdt_pkg::sample_t              sample,
  input logic                             result_valid,
  input logic                             result_stall,
  input pidvdt_pkg::result_t              result,
  input logic                             write_enable,
  input logic [pidvdt_pkg::CFG_IDX_W-1:0] write_index,
  input logic [pidvdt_pkg::GAIN_W-1:0]    write_data
);
  import pidvdt_pkg::*;

  `CHK_ASSERT(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result transaction changed or vanished")
  `CHK_ASSERT(a_busy_after_accept, clk, rst, sample_valid && !sample_stall |-> ##50 sample_stall, "controller took a new sample too early")
  `CHK_ASSERT_ALWAYS(a_reset_no_result, clk, rst |=> !result_valid, "result valid straight after reset")
  `CHK_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> !sample_stall, "controller not idle after reset")

endmodule

bind pid_controller_variable_dt pidvdt_chk u_chk (.*);

// ===== dv/tb_pid_controller_variable_dt.sv =====
// self-checking testbench for the variable interval pid controller
`timescale 1ns / 1ps

module tb_pid_controller_variable_dt;
  import pidvdt_pkg::*;

  // write index with no register behind it, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam longint INTEG_MAX = 64'sd140737488355327;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD = 400;
  // drain allowance after the last result
  localparam int DRAIN_CYCLES = 100;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = '0;
  logic [GAIN_W-1:0]    write_data = '0;

  pid_controller_variable_dt u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  always #4 clk = ~clk;

  // controller state as the block should hold it
  longint            kp, ki, kd;
  logic [TIME_W-1:0] last_time;
  longint            integ;
  longint            last_err;

  sample_t sample_q[$];          // samples still to be offered
  result_t expected_drive_q[$];  // predicted results, oldest first
  result_t want;

  int n_queued, n_accepted, n_checked, n_fail;
  int n_zero, n_sat, n_settings;
  int send_wait, recv_wait;
  int hold_req, hold_served;
  bit steady;                    // no idling on either side when set
  logic [TIME_W-1:0] ts_cursor;

  // one step of the parallel-form controller, updating the shadow state
  function automatic result_t pid_update(sample_t s);
    logic [TIME_W-1:0] dt;
    longint err, sum, deriv, acc, drv;
    result_t r;
    r = '0;
    dt = s.timestamp_ms - last_time;
    err = $signed(s.target) - $signed(s.measurement);
    sum = integ + err * longint'({32'd0, dt});
    if (sum > INTEG_MAX) begin
      sum = INTEG_MAX;
      r.saturated = 1'b1;
    end else if (sum < INTEG_MIN) begin
      sum = INTEG_MIN;
      r.saturated = 1'b1;
    end
    integ = sum;
    // zero interval: derivative forced to zero, flagged
    if (dt == '0) begin
      deriv = 0;
      r.zero_interval = 1'b1;
    end else begin
      deriv = (err - last_err) / longint'({32'd0, dt});
    end
    acc = kp * err + ki * sum + kd * deriv;
    drv = acc >>> GAIN_FRAC_BITS;   // floor, not toward zero
    if (drv > DRIVE_MAX) begin
      drv = DRIVE_MAX;
      r.saturated = 1'b1;
    end else if (drv < DRIVE_MIN) begin
      drv = DRIVE_MIN;
      r.saturated = 1'b1;
    end
    r.drive = drv[DRIVE_W-1:0];
    last_err = err;
    last_time = s.timestamp_ms;
    return r;
  endfunction

  // sender: offers queued samples, predicts each one as it is taken
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_drive_q.push_back(pid_update(sample));
        n_accepted++;
        send_wait = steady ? 0 : $urandom_range(0, 6);
      end
      // a stalled transaction holds its payload
      if (!sample_valid || !sample_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          sample_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          sample <= sample_q.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls per result, plus the long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (result_valid && !result_stall) begin
        n_checked++;
        if (expected_drive_q.size() == 0) begin
          $error("result transaction with nothing expected: drive %0d",
                 $signed(result.drive));
          n_fail++;
        end else begin
          want = expected_drive_q.pop_front();
          if (result.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive),
                   $signed(result.drive));
            n_fail++;
          end
          if (result.zero_interval !== want.zero_interval) begin
            $error("zero_interval: expected %0b, got %0b", want.zero_interval,
                   result.zero_interval);
            n_fail++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated,
                   result.saturated);
            n_fail++;
          end
        end
        n_zero += int'(result.zero_interval);
        n_sat  += int'(result.saturated);
        recv_wait = steady ? 0 : $urandom_range(0, 6);
      end else if (result_valid && recv_wait > 0) begin
        // stall cycles only count down while a result is waiting
        recv_wait--;
      end
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        recv_wait = LONG_HOLD;
      end
      result_stall <= (recv_wait != 0);
    end
  end

  function automatic sample_t make_sample(logic [TIME_W-1:0] ts, logic [VAL_W-1:0] meas,
                                          logic [VAL_W-1:0] tgt);
    sample_t s;
    s.timestamp_ms = ts;
    s.measurement  = meas;
    s.target       = tgt;
    return s;
  endfunction

  task automatic queue_sample(logic [TIME_W-1:0] ts, logic [VAL_W-1:0] meas,
                              logic [VAL_W-1:0] tgt);
    sample_q.push_back(make_sample(ts, meas, tgt));
    ts_cursor = ts;
    n_queued++;
  endtask

  // register write; the shadow gains follow only for indexes that exist
  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_GAIN_P: kp = longint'($signed(val));
      REG_GAIN_I: ki = longint'($signed(val));
      REG_GAIN_D: kd = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                           logic [GAIN_W-1:0] d);
    write_gain(REG_GAIN_P, p);
    write_gain(REG_GAIN_I, i);
    write_gain(REG_GAIN_D, d);
    n_settings++;
  endtask

  // sender side pause: every result back before anything else happens
  task automatic wait_idle();
    while (n_checked != n_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly a steadily advancing clock with setpoint tracking, some noise
  task automatic queue_random(int n);
    int pick;
    logic [VAL_W-1:0] tgt, meas;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        ts_cursor = $urandom();
      else if (pick == 3)
        ts_cursor = ts_cursor + $urandom();
      else if (pick > 3)
        ts_cursor = ts_cursor + $urandom_range(1, 40);
      // pick 1 or 2 keeps the timestamp: zero interval
      tgt = VAL_W'($urandom());
      if ($urandom_range(0, 3) == 0)
        meas = VAL_W'($urandom());
      else
        meas = VAL_W'(tgt + $urandom_range(0, 200) - 100);
      queue_sample(ts_cursor, meas, tgt);
    end
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0;
    last_time = '0; integ = 0; last_err = 0;
    n_queued = 0; n_accepted = 0; n_checked = 0; n_fail = 0;
    n_zero = 0; n_sat = 0; n_settings = 0;
    hold_req = 0; hold_served = 0;
    steady = 1'b0;
    ts_cursor = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: unit proportional, small integral, negative derivative gain
    set_gains(16'd256, 16'd1, -16'sd300);
    // index with no register behind it
    write_gain(REG_NONE, 16'hFFFF);
    // first sample after reset at time zero gives a zero interval
    queue_sample(32'd0, 16'd0, 16'd100);
    queue_sample(32'd1, 16'h8000, 16'h7FFF);
    queue_sample(32'd2, 16'h7FFF, 16'h8000);
    // huge interval at full error: integral and drive clip high
    queue_sample(32'hFFFF_FFFF, 16'h8000, 16'h7FFF);
    // timestamp wraps round to zero
    queue_sample(32'd0, 16'd0, 16'd5);
    queue_sample(32'd0, 16'd10, 16'd0);
    // derivative -7/3 truncates toward zero
    queue_sample(32'd3, 16'd0, -16'sd17);
    // drive the integral down until it clips low
    queue_sample(32'h8000_0003, 16'h7FFF, 16'h8000);
    queue_sample(32'h0000_0002, 16'h7FFF, 16'h8000);
    queue_sample(32'h8000_0002, 16'h7FFF, 16'h8000);
    wait_idle();

    // directed: floor rounding of small negative products
    set_gains(16'd1, 16'd0, 16'd0);
    queue_sample(32'h8000_0003, 16'd0, -16'sd1);
    queue_sample(32'h8000_0004, 16'd0, 16'd1);
    queue_sample(32'h8000_0005, 16'd256, 16'd0);
    queue_sample(32'h8000_0006, 16'd257, 16'd0);
    queue_sample(32'h8000_0007, 16'd0, 16'd255);
    wait_idle();

    // directed: gain extremes of opposite sign
    set_gains(16'h8000, 16'd0, 16'h7FFF);
    write_gain(REG_NONE, 16'h0000);
    queue_sample(32'h8000_0008, 16'h8000, 16'h7FFF);
    queue_sample(32'h8000_0009, 16'h7FFF, 16'h8000);
    queue_sample(32'h8000_0009, 16'd1, 16'd0);
    queue_sample(32'h8000_0109, 16'd0, 16'd3);
    wait_idle();

    // random phases over a spread of gain settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF);
        1: set_gains(16'h8000, 16'h8000, 16'h8000);
        2: set_gains(16'd256, 16'd0, 16'd512);
        3: set_gains(16'd0, 16'd0, 16'd0);
        default: set_gains(GAIN_W'($urandom()), GAIN_W'($urandom_range(0, 15) - 8),
                           GAIN_W'($urandom()));
      endcase
      steady = (ph == 5);
      queue_random(80);
      // receiver holds off while the sender keeps offering
      if (ph == 2 || ph == 6) hold_req++;
      wait_idle();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_drive_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive_q.size());
      n_fail++;
    end
    $display("%0d sample transactions over %0d gain settings checked,",
             n_accepted, n_settings);
    $display("%0d with a zero interval and %0d clipped", n_zero, n_sat);
    if (n_fail == 0)
      $display("tb_pid_controller_variable_dt OK");
    else
      $display("tb_pid_controller_variable_dt NOT OK");
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("tb_pid_controller_variable_dt NOT OK");
    $finish;
  end

endmodule
